>>> sv/lzd_pkg.sv
`timescale 1ns / 1ps

package lzd_pkg;

   localparam int WINDOW_BITS      = 15;
   localparam int BYTES_PER_RESULT = 8;
   localparam int MIN_MATCH        = 3;
   localparam int WIN_SIZE         = 1 << WINDOW_BITS;
   localparam int WIN_DEPTH        = WIN_SIZE;

   localparam int PTR_W  = WINDOW_BITS;
   localparam int DIST_W = 15;
   localparam int LCODE_W = 8;
   localparam int LEN_W  = 9;
   localparam int CNT_W  = 4;
   localparam int OUT_W  = 64;
   localparam int SIZE_W = 32;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_ADDR_W-1:0] REG_EXPECTED_SIZE = '0;
   localparam logic [SIZE_W-1:0]     EXPECTED_SIZE_RESET = '1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COPY,
      ST_ERROR
   } state_type;

   typedef struct packed {
      logic               is_literal;
      logic [7:0]         literal_byte;
      logic [DIST_W-1:0]  distance;
      logic [LCODE_W-1:0] length_code;
      logic               last_token;
   } token_type;

   typedef struct packed {
      logic [OUT_W-1:0] out_bytes;
      logic [CNT_W-1:0] byte_count;
      logic             error;
      logic             last;
   } result_type;

   // verdict on a token at the moment it is taken in
   typedef struct packed {
      logic             bad;
      logic [LEN_W-1:0] len;
   } check_type;

endpackage

>>> sv/lzd_ifs.sv
`timescale 1ns / 1ps

interface lzd_req_if;
   import lzd_pkg::*;

   logic               valid;
   logic               ready;
   logic               is_literal;
   logic [7:0]         literal_byte;
   logic [DIST_W-1:0]  distance;
   logic [LCODE_W-1:0] length_code;
   logic               last_token;

   modport source (
      output valid, is_literal, literal_byte, distance, length_code, last_token,
      input  ready
   );
   modport sink (
      input  valid, is_literal, literal_byte, distance, length_code, last_token,
      output ready
   );
endinterface

interface lzd_rsp_if;
   import lzd_pkg::*;

   logic             valid;
   logic             ready;
   logic [OUT_W-1:0] out_bytes;
   logic [CNT_W-1:0] byte_count;
   logic             error;
   logic             last;

   modport source (
      output valid, out_bytes, byte_count, error, last,
      input  ready
   );
   modport sink (
      input  valid, out_bytes, byte_count, error, last,
      output ready
   );
endinterface

>>> sv/lzss_token_decoder_core.sv
`timescale 1ns / 1ps

// channel   direction  handshake        payload
// req_chan  in         valid/ready      is_literal, literal_byte, distance, length_code,
//                                       last_token
// rsp_chan  out        valid/ready      out_bytes, byte_count, error, last
// csr       in         apb psel/penable expected_size at byte address 0
//
// a token is taken in while idle, then the copy unit moves one byte per cycle when not
// stalled, through the simple dual-port history memory; an error token passes through the
// error state, which emits one error result
// reset is synchronous; the history memory is not cleared, distance checks keep reads
// inside the bytes written in the current stream
// a full result register stalls the copy unit only on a byte that closes a result

module lzss_token_decoder_core (
   input  logic                           clock,
   input  logic                           reset,
   lzd_req_if.sink                        req_chan,
   lzd_rsp_if.source                      rsp_chan,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [lzd_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [lzd_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [lzd_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);
   import lzd_pkg::*;

   logic [SIZE_W-1:0] expected_size;
   token_type         token;
   check_type         check;
   result_type        result;
   logic              req_ready;
   logic              rsp_valid;

   assign token.is_literal   = req_chan.is_literal;
   assign token.literal_byte = req_chan.literal_byte;
   assign token.distance     = req_chan.distance;
   assign token.length_code  = req_chan.length_code;
   assign token.last_token   = req_chan.last_token;

   lzd_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready),
      .expected_size (expected_size)
   );

   lzd_stream_track u_track (
      .clock         (clock),
      .reset         (reset),
      .accept        (req_chan.valid && req_ready),
      .token         (token),
      .expected_size (expected_size),
      .check         (check)
   );

   lzd_copy_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .token     (token),
      .check     (check),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .result    (result)
   );

   assign req_chan.ready      = req_ready;
   assign rsp_chan.valid      = rsp_valid;
   assign rsp_chan.out_bytes  = result.out_bytes;
   assign rsp_chan.byte_count = result.byte_count;
   assign rsp_chan.error      = result.error;
   assign rsp_chan.last       = result.last;

endmodule

>>> sv/lzd_csr.sv
`timescale 1ns / 1ps

module lzd_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [lzd_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [lzd_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [lzd_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready,
   output logic [lzd_pkg::SIZE_W-1:0]       expected_size
);
   import lzd_pkg::*;

   logic [SIZE_W-1:0] expected_ff;
   logic [SIZE_W-1:0] expected_in;
   logic              wr_hit;

   assign wr_hit = psel && penable && pwrite && (paddr == REG_EXPECTED_SIZE);

   always_comb begin
      expected_in = expected_ff;
      if (wr_hit) begin
         expected_in = pwdata[SIZE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_ff <= EXPECTED_SIZE_RESET;
      end else begin
         expected_ff <= expected_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr == REG_EXPECTED_SIZE) begin
         prdata = CSR_DATA_W'(expected_ff);
      end
   end

   assign pready        = 1'b1;
   assign expected_size = expected_ff;

endmodule

>>> sv/lzd_stream_track.sv
`timescale 1ns / 1ps

module lzd_stream_track (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  lzd_pkg::token_type           token,
   input  logic [lzd_pkg::SIZE_W-1:0]   expected_size,
   output lzd_pkg::check_type           check
);
   import lzd_pkg::*;

   logic [SIZE_W-1:0] produced_ff;
   logic [SIZE_W-1:0] produced_in;
   logic              err_seen_ff;
   logic              err_seen_in;
   logic [LEN_W-1:0]  len;
   logic [SIZE_W:0]   total;
   logic              dist_bad;
   logic              size_bad;

   assign len = token.is_literal ? LEN_W'(1) : (LEN_W'(token.length_code) + LEN_W'(MIN_MATCH));
   assign total = {1'b0, produced_ff} + (SIZE_W + 1)'(len);
   assign size_bad = total > {1'b0, expected_size};
   assign dist_bad = !token.is_literal &&
                     ((token.distance == '0) ||
                      ((SIZE_W + 1)'(token.distance) > {1'b0, produced_ff}) ||
                      ((SIZE_W + 1)'(token.distance) > (SIZE_W + 1)'(WIN_SIZE)));

   assign check.bad = err_seen_ff || dist_bad || size_bad;
   assign check.len = len;

   always_comb begin
      produced_in = produced_ff;
      err_seen_in = err_seen_ff;
      if (accept) begin
         if (token.last_token) begin
            produced_in = '0;
            err_seen_in = 1'b0;
         end else if (check.bad) begin
            err_seen_in = 1'b1;
         end else begin
            produced_in = total[SIZE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         produced_ff <= '0;
         err_seen_ff <= 1'b0;
      end else begin
         produced_ff <= produced_in;
         err_seen_ff <= err_seen_in;
      end
   end

endmodule

>>> sv/lzd_copy_engine.sv
`timescale 1ns / 1ps

module lzd_copy_engine (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  lzd_pkg::token_type  token,
   input  lzd_pkg::check_type  check,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output lzd_pkg::result_type result
);
   import lzd_pkg::*;

   state_type         state_ff, state_in;
   logic [PTR_W-1:0]  dst_ff, dst_in;
   logic [PTR_W-1:0]  src_ff, src_in;
   logic [LEN_W-1:0]  remain_ff, remain_in;
   logic              lit_ff, lit_in;
   logic [7:0]        lbyte_ff, lbyte_in;
   logic              dist1_ff, dist1_in;
   logic              end_ff, end_in;
   logic [7:0]        prev_ff, prev_in;
   logic [OUT_W-1:0]  acc_ff, acc_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              out_valid_ff, out_valid_in;
   result_type        out_ff, out_in;

   logic [7:0]        hist_mem [WIN_DEPTH];
   logic [7:0]        rd_data_ff;
   logic              wr_en;

   logic              accept;
   logic              slot_free;
   logic [7:0]        byte_val;
   logic              last_byte;
   logic              emit;
   logic              advance;
   logic [OUT_W-1:0]  acc_next;

   assign accept    = req_valid && req_ready;
   assign slot_free = !out_valid_ff || rsp_ready;
   // distance one reads the byte written in the same cycle, so take it from prev
   assign byte_val  = lit_ff ? lbyte_ff : (dist1_ff ? prev_ff : rd_data_ff);
   assign last_byte = remain_ff == LEN_W'(1);
   assign emit      = (cnt_ff == CNT_W'(BYTES_PER_RESULT - 1)) || last_byte;
   assign advance   = (state_ff == ST_COPY) && (!emit || slot_free);
   assign acc_next  = acc_ff | (OUT_W'(byte_val) << {cnt_ff, 3'b000});

   always_comb begin
      state_in     = state_ff;
      dst_in       = dst_ff;
      src_in       = src_ff;
      remain_in    = remain_ff;
      lit_in       = lit_ff;
      lbyte_in     = lbyte_ff;
      dist1_in     = dist1_ff;
      end_in       = end_ff;
      prev_in      = prev_ff;
      acc_in       = acc_ff;
      cnt_in       = cnt_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_in       = out_ff;
      wr_en        = 1'b0;
      req_ready    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (accept) begin
               if (check.bad) begin
                  state_in = ST_ERROR;
                  if (token.last_token) begin
                     dst_in = '0;
                  end
               end else begin
                  state_in  = ST_COPY;
                  remain_in = check.len;
                  lit_in    = token.is_literal;
                  lbyte_in  = token.literal_byte;
                  dist1_in  = token.distance == DIST_W'(1);
                  end_in    = token.last_token;
                  src_in    = dst_ff - PTR_W'(token.distance);
                  acc_in    = '0;
                  cnt_in    = '0;
               end
            end
         end
         ST_COPY: begin
            if (advance) begin
               wr_en     = 1'b1;
               prev_in   = byte_val;
               dst_in    = dst_ff + PTR_W'(1);
               src_in    = src_ff + PTR_W'(1);
               remain_in = remain_ff - LEN_W'(1);
               if (emit) begin
                  out_valid_in      = 1'b1;
                  out_in.out_bytes  = acc_next;
                  out_in.byte_count = cnt_ff + CNT_W'(1);
                  out_in.error      = 1'b0;
                  out_in.last       = last_byte;
                  acc_in            = '0;
                  cnt_in            = '0;
               end else begin
                  acc_in = acc_next;
                  cnt_in = cnt_ff + CNT_W'(1);
               end
               if (last_byte) begin
                  state_in = ST_IDLE;
                  if (end_ff) begin
                     dst_in = '0;
                  end
               end
            end
         end
         ST_ERROR: begin
            if (slot_free) begin
               out_valid_in      = 1'b1;
               out_in.out_bytes  = '0;
               out_in.byte_count = '0;
               out_in.error      = 1'b1;
               out_in.last       = 1'b1;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         dst_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dst_ff       <= dst_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff    <= src_in;
      remain_ff <= remain_in;
      lit_ff    <= lit_in;
      lbyte_ff  <= lbyte_in;
      dist1_ff  <= dist1_in;
      end_ff    <= end_in;
      prev_ff   <= prev_in;
      acc_ff    <= acc_in;
      cnt_ff    <= cnt_in;
      out_ff    <= out_in;
   end

   // read address follows the next source pointer, so the registered data lines up with src_ff
   always_ff @(posedge clock) begin
      rd_data_ff <= hist_mem[src_in];
      if (wr_en) begin
         hist_mem[dst_ff] <= byte_val;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign result    = out_ff;

   a_bad_goes_error: assert property (@(posedge clock) disable iff (reset)
      accept && check.bad |=> state_ff == ST_ERROR)
      else $error("bad token did not enter error state");

   a_copy_has_work: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_COPY |-> remain_ff != '0)
      else $error("copy with no bytes left");

   a_result_shape: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_ff.error ? (out_ff.byte_count == '0 && out_ff.last)
                        : (out_ff.byte_count != '0 &&
                           out_ff.byte_count <= CNT_W'(BYTES_PER_RESULT))))
      else $error("malformed result");

   a_pack_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_COPY |-> cnt_ff < CNT_W'(BYTES_PER_RESULT))
      else $error("pack count overran");

   a_copy_ends_idle: assert property (@(posedge clock) disable iff (reset)
      advance && last_byte |=> state_ff == ST_IDLE && out_valid_ff && out_ff.last)
      else $error("final byte did not close the token");

endmodule
